@@ rtl/adsr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package adsr_pkg;

    // Register field width and number of codes per rate register
    localparam int RATE_W      = 7;
    localparam int RATE_LEVELS = 1 << RATE_W;

    // Width of the reported level, unsigned Q1.16
    localparam int LEVEL_OUT_W = 17;

    // Scale divisors of the rate registers
    localparam longint unsigned ATTACK_DIV  = 64'd32512;   // 127 * 256
    localparam longint unsigned COEF_DIV    = 64'd130048;  // 127 * 1024
    localparam longint unsigned SUSTAIN_DIV = 64'd127;

    // Register indexes on the config port
    localparam logic [1:0] REG_ATTACK  = 2'd0;
    localparam logic [1:0] REG_DECAY   = 2'd1;
    localparam logic [1:0] REG_SUSTAIN = 2'd2;
    localparam logic [1:0] REG_RELEASE = 2'd3;

    // Command codes of an input word
    localparam logic [1:0] CMD_TICK    = 2'd0;
    localparam logic [1:0] CMD_KEY_ON  = 2'd1;
    localparam logic [1:0] CMD_KEY_OFF = 2'd2;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_ATTACK  = 2'd1,
        MODE_DECAY   = 2'd2,
        MODE_RELEASE = 2'd3
    } mode_t;

    // One input word
    typedef struct packed {
        logic [1:0] cmd;
        logic       fade;
    } item_t;

endpackage

`default_nettype wire

@@ rtl/adsr_envelope_generator.sv @@
`timescale 1ns / 1ps
`default_nettype none

// ADSR envelope for one voice. Each input word is a sample tick, key-on or
// key-off; each produces exactly one result word with the new level (Q1.16)
// and mode. The block takes one word per clock when the result side keeps
// up. A word passes through an input register, one multiply step shared
// by decay and release, and the result register, which also holds the
// envelope state; the result register takes it once empty or taken.
// Register writes decode the rate codes through constant tables into
// increments, sustain targets and reciprocal coefficients, so write
// them only while no word is in flight. There is no clearing pass;
// the block is ready right after reset.
module adsr_envelope_generator #(
    parameter int LEVEL_FRAC_BITS = 24
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // input words
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [1:0]                        s_cmd,
    input  wire logic                              s_fade_request,
    // result words
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [adsr_pkg::LEVEL_OUT_W-1:0]       m_level,
    output logic [1:0]                             m_mode,
    // register writes
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [1:0]                        cfg_addr,
    input  wire logic [adsr_pkg::RATE_W-1:0]       cfg_data
);
    import adsr_pkg::*;

    localparam int F  = LEVEL_FRAC_BITS;
    localparam int LW = F + 1;

    localparam logic [LW-1:0] LEVEL_ONE   = LW'(1) << F;
    localparam logic [LW-1:0] LEVEL_FLOOR = LW'(1) << (F - 16);

    logic          in_valid_reg;
    logic          in_valid_next;
    item_t         in_item_reg;
    logic          m_valid_reg;
    logic          m_valid_next;
    logic [LW-1:0] level_reg;
    mode_t         mode_reg;

    logic          s_accept;
    logic          out_free;
    logic          advance;
    item_t         s_item;
    mode_t         mode_next;
    logic [LW-1:0] level_next;

    logic [F-8:0]  attack_inc;
    logic [F:0]    sustain;
    logic [F+7:0]  decay_coef;
    logic [F+7:0]  release_coef;

    assign cfg_ready = 1'b1;

    adsr_cfg #(
        .LEVEL_FRAC_BITS(LEVEL_FRAC_BITS)
    ) u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .wr_en        (cfg_valid),
        .wr_addr      (cfg_addr),
        .wr_data      (cfg_data),
        .attack_inc   (attack_inc),
        .sustain      (sustain),
        .decay_coef   (decay_coef),
        .release_coef (release_coef)
    );

    adsr_step #(
        .LEVEL_FRAC_BITS(LEVEL_FRAC_BITS)
    ) u_step (
        .item         (in_item_reg),
        .mode_i       (mode_reg),
        .level_i      (level_reg),
        .attack_inc   (attack_inc),
        .sustain      (sustain),
        .decay_coef   (decay_coef),
        .release_coef (release_coef),
        .mode_o       (mode_next),
        .level_o      (level_next)
    );

    // Handshake: the result register frees when empty or taken
    assign out_free      = !m_valid_reg || m_ready;
    assign advance       = in_valid_reg && out_free;
    assign s_ready       = !in_valid_reg || advance;
    assign s_accept      = s_valid && s_ready;
    assign s_item        = '{cmd: s_cmd, fade: s_fade_request};
    assign in_valid_next = s_accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign m_valid_next  = advance ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
        if (s_accept) begin
            in_item_reg <= s_item;
        end
    end

    // Result register, doubling as envelope state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            level_reg   <= '0;
            mode_reg    <= MODE_IDLE;
        end else begin
            m_valid_reg <= m_valid_next;
            if (advance) begin
                level_reg <= level_next;
                mode_reg  <= mode_next;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_level = level_reg[F -: LEVEL_OUT_W];
    assign m_mode  = mode_reg;

`ifndef SYNTHESIS
    a_level_max: assert property (@(posedge aclk) disable iff (!aresetn)
        level_reg <= LEVEL_ONE)
        else $error("envelope level above full scale");

    a_level_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        level_reg != '0 |-> level_reg >= LEVEL_FLOOR)
        else $error("nonzero level below floor");

    a_key_on: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_item_reg.cmd == CMD_KEY_ON
        |=> mode_reg == MODE_ATTACK && level_reg == '0)
        else $error("key-on did not restart attack");

    a_attack_done: assert property (@(posedge aclk) disable iff (!aresetn)
        mode_reg == MODE_DECAY && $past(mode_reg) == MODE_ATTACK
        |-> level_reg == LEVEL_ONE || $past(in_item_reg.fade) == 1'b1)
        else $error("attack ended below full scale");

    a_no_result_without_word: assert property (@(posedge aclk) disable iff (!aresetn)
        !$past(advance) && !$past(m_valid_reg) |-> !m_valid_reg)
        else $error("result word without input word");
`endif

endmodule

`default_nettype wire

@@ rtl/adsr_cfg.sv @@
`timescale 1ns / 1ps
`default_nettype none

module adsr_cfg #(
    parameter int LEVEL_FRAC_BITS = 24
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        wr_en,
    input  wire logic [1:0]                  wr_addr,
    input  wire logic [adsr_pkg::RATE_W-1:0] wr_data,
    output logic [LEVEL_FRAC_BITS-8:0]       attack_inc,
    output logic [LEVEL_FRAC_BITS:0]         sustain,
    output logic [LEVEL_FRAC_BITS+7:0]       decay_coef,
    output logic [LEVEL_FRAC_BITS+7:0]       release_coef
);
    import adsr_pkg::*;

    localparam int F    = LEVEL_FRAC_BITS;
    localparam int IW   = F - 7;    // attack increment, at most 2^(F-8)
    localparam int SW   = F + 1;    // sustain target, at most 1.0
    localparam int CW   = F + 8;    // coefficient, at most 2^(F+7)
    localparam int KSH  = F + 17;   // reciprocal precision shift

    logic [IW-1:0] atk_tbl [RATE_LEVELS];
    logic [SW-1:0] sus_tbl [RATE_LEVELS];
    logic [CW-1:0] coef_tbl [RATE_LEVELS];

    logic [IW-1:0] attack_inc_reg;
    logic [SW-1:0] sustain_reg;
    logic [CW-1:0] decay_coef_reg;
    logic [CW-1:0] release_coef_reg;

    // Elaboration-time tables: per-tick increment, sustain target and
    // rounded-up reciprocal coefficient rate * 2^KSH / (127*1024)
    for (genvar i = 0; i < RATE_LEVELS; i++) begin : g_tbl
        assign atk_tbl[i]  = IW'((64'(i) << F) / ATTACK_DIV);
        assign sus_tbl[i]  = SW'((64'(i) << F) / SUSTAIN_DIV);
        assign coef_tbl[i] = CW'(((64'(i) << KSH) + COEF_DIV - 64'd1) / COEF_DIV);
    end

    // Register writes store the decoded operand, not the raw code
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attack_inc_reg   <= '0;
            sustain_reg      <= '0;
            decay_coef_reg   <= '0;
            release_coef_reg <= '0;
        end else if (wr_en) begin
            unique case (wr_addr)
                REG_ATTACK:  attack_inc_reg   <= atk_tbl[wr_data];
                REG_DECAY:   decay_coef_reg   <= coef_tbl[wr_data];
                REG_SUSTAIN: sustain_reg      <= sus_tbl[wr_data];
                REG_RELEASE: release_coef_reg <= coef_tbl[wr_data];
                default:     ;
            endcase
        end
    end

    assign attack_inc   = attack_inc_reg;
    assign sustain      = sustain_reg;
    assign decay_coef   = decay_coef_reg;
    assign release_coef = release_coef_reg;

endmodule

`default_nettype wire

@@ rtl/adsr_step.sv @@
`timescale 1ns / 1ps
`default_nettype none

module adsr_step #(
    parameter int LEVEL_FRAC_BITS = 24
) (
    input  wire adsr_pkg::item_t       item,
    input  wire adsr_pkg::mode_t       mode_i,
    input  wire logic [LEVEL_FRAC_BITS:0]   level_i,
    input  wire logic [LEVEL_FRAC_BITS-8:0] attack_inc,
    input  wire logic [LEVEL_FRAC_BITS:0]   sustain,
    input  wire logic [LEVEL_FRAC_BITS+7:0] decay_coef,
    input  wire logic [LEVEL_FRAC_BITS+7:0] release_coef,
    output adsr_pkg::mode_t            mode_o,
    output logic [LEVEL_FRAC_BITS:0]   level_o
);
    import adsr_pkg::*;

    localparam int F   = LEVEL_FRAC_BITS;
    localparam int LW  = F + 1;
    localparam int CW  = F + 8;
    localparam int PW  = LW + CW;
    localparam int KSH = F + 17;

    localparam logic [LW-1:0] LEVEL_ONE   = LW'(1) << F;
    localparam logic [LW-1:0] LEVEL_FADE  = LW'(1) << (F - 9);
    localparam logic [LW-1:0] LEVEL_FLOOR = LW'(1) << (F - 16);

    logic                 is_decay;
    logic [LW-1:0]        target;
    logic [CW-1:0]        coef;
    logic signed [LW:0]   diff;
    logic [LW:0]          diff_abs;
    logic [LW-1:0]        mag;
    logic [PW-1:0]        prod;
    logic [LW-1:0]        step_q;
    logic [LW-1:0]        exp_level;
    logic [LW-1:0]        atk_sum;

    // Shared exponential step: release is decay toward zero.
    // step = trunc(|L - target| * rate / (127*1024)), exact via reciprocal
    always_comb begin
        is_decay = (mode_i == MODE_DECAY);
        target   = is_decay ? sustain : '0;
        coef     = is_decay ? decay_coef : release_coef;
        diff     = $signed({1'b0, level_i}) - $signed({1'b0, target});
        diff_abs = diff[LW] ? (LW+1)'(0) - diff : diff;
        mag      = diff_abs[LW-1:0];
        prod     = PW'(mag) * PW'(coef);
        step_q   = LW'(prod[PW-1:KSH]);
        exp_level = diff[LW] ? level_i + step_q : level_i - step_q;
        atk_sum  = level_i + LW'(attack_inc);
    end

    // Command decode, mode step, fade and floor
    always_comb begin
        logic [LW-1:0] lv;
        mode_o = mode_i;
        lv     = level_i;
        case (item.cmd)
            CMD_TICK: begin
                case (mode_i)
                    MODE_ATTACK: begin
                        if (atk_sum > LEVEL_ONE) begin
                            lv     = LEVEL_ONE;
                            mode_o = MODE_DECAY;
                        end else begin
                            lv = atk_sum;
                        end
                    end
                    MODE_DECAY, MODE_RELEASE: lv = exp_level;
                    default: lv = level_i;
                endcase
                if (item.fade) begin
                    lv = (lv < LEVEL_FADE) ? '0 : lv - LEVEL_FADE;
                end
                if (lv < LEVEL_FLOOR) begin
                    lv = '0;
                end
            end
            CMD_KEY_ON: begin
                mode_o = MODE_ATTACK;
                lv     = '0;
            end
            CMD_KEY_OFF: mode_o = MODE_RELEASE;
            default: ;
        endcase
        level_o = lv;
    end

endmodule

`default_nettype wire

@@ dv/adsr_checker.sv @@
`timescale 1ns / 1ps

// Watches the input, result and register channels of the envelope generator,
// keeps its own envelope state and checks every result word in order.
module adsr_checker #(
    parameter int LEVEL_FRAC_BITS = 24
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  logic [1:0]                      s_cmd,
    input  logic                            s_fade_request,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  logic [adsr_pkg::LEVEL_OUT_W-1:0] m_level,
    input  logic [1:0]                      m_mode,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [1:0]                      cfg_addr,
    input  logic [adsr_pkg::RATE_W-1:0]     cfg_data,
    output int                              fail_count,
    output int                              words_in_flight
);

    import adsr_pkg::*;

    localparam longint unsigned LEVEL_ONE   = 64'd1 << LEVEL_FRAC_BITS;
    localparam longint unsigned LEVEL_FLOOR = 64'd1 << (LEVEL_FRAC_BITS - 16);
    localparam longint unsigned FADE_STEP   = 64'd1 << (LEVEL_FRAC_BITS - 9);

    typedef struct packed {
        logic [LEVEL_OUT_W-1:0] level;
        mode_t                  mode;
    } env_word_t;

    env_word_t envelope_q[$];

    // register copies
    logic [RATE_W-1:0] attack_code;
    logic [RATE_W-1:0] decay_code;
    logic [RATE_W-1:0] sustain_code;
    logic [RATE_W-1:0] release_code;

    // envelope state
    mode_t                    env_mode;
    logic [LEVEL_FRAC_BITS:0] env_level;

    initial begin
        fail_count      = 0;
        words_in_flight = 0;
    end

    // One input word applied to the envelope state; returns the result word
    task automatic advance_envelope(input logic [1:0] cmd, input logic fade,
                                    output env_word_t word);
        longint unsigned lvl;
        longint          target;
        longint          delta;
        longint          step_amt;
        lvl = env_level;
        if (cmd == CMD_TICK) begin
            case (env_mode)
                MODE_ATTACK: begin
                    lvl += (longint'(attack_code) << LEVEL_FRAC_BITS) / ATTACK_DIV;
                    if (lvl > LEVEL_ONE) begin
                        lvl      = LEVEL_ONE;
                        env_mode = MODE_DECAY;
                    end
                end
                MODE_DECAY: begin
                    // signed distance to sustain, step truncated toward zero
                    target   = longint'((longint'(sustain_code) << LEVEL_FRAC_BITS)
                                        / SUSTAIN_DIV);
                    delta    = longint'(lvl) - target;
                    step_amt = (delta * longint'(decay_code)) / longint'(COEF_DIV);
                    lvl      = longint'(lvl) - step_amt;
                end
                MODE_RELEASE: begin
                    lvl -= (lvl * longint'(release_code)) / COEF_DIV;
                end
                default: ;
            endcase
            if (fade) begin
                if (lvl < FADE_STEP) lvl = 0;
                else lvl -= FADE_STEP;
            end
            if (lvl < LEVEL_FLOOR) lvl = 0;
        end else if (cmd == CMD_KEY_ON) begin
            env_mode = MODE_ATTACK;
            lvl      = 0;
        end else if (cmd == CMD_KEY_OFF) begin
            env_mode = MODE_RELEASE;
        end
        env_level  = lvl[LEVEL_FRAC_BITS:0];
        word.level = LEVEL_OUT_W'(lvl >> (LEVEL_FRAC_BITS - 16));
        word.mode  = env_mode;
    endtask

    // Sample all channels at the rising edge
    always @(posedge aclk) begin : monitor
        env_word_t predicted;
        env_word_t oldest;
        if (!aresetn) begin
            attack_code  = '0;
            decay_code   = '0;
            sustain_code = '0;
            release_code = '0;
            env_mode     = MODE_IDLE;
            env_level    = '0;
            envelope_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_addr)
                    REG_ATTACK:  attack_code  = cfg_data;
                    REG_DECAY:   decay_code   = cfg_data;
                    REG_SUSTAIN: sustain_code = cfg_data;
                    REG_RELEASE: release_code = cfg_data;
                    default: ;
                endcase
            end
            // result word against the oldest prediction
            if (m_valid && m_ready) begin
                if (envelope_q.size() == 0) begin
                    $display("%0t: unexpected result word, level %0d mode %0d",
                             $time, m_level, m_mode);
                    fail_count++;
                end else begin
                    oldest = envelope_q.pop_front();
                    if (m_level !== oldest.level) begin
                        $display("%0t: level mismatch, expected %0d, actual %0d",
                                 $time, oldest.level, m_level);
                        fail_count++;
                    end
                    if (m_mode !== oldest.mode) begin
                        $display("%0t: mode mismatch, expected %0d, actual %0d",
                                 $time, oldest.mode, m_mode);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                advance_envelope(s_cmd, s_fade_request, predicted);
                envelope_q.push_back(predicted);
            end
        end
        words_in_flight = envelope_q.size();
    end

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps

module tb;

    import adsr_pkg::*;

    localparam int FRAC_BITS    = 24;
    localparam int RANDOM_WORDS = 700;
    localparam int STALL_CYCLES = 300;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int IDLE_PCT     = 9;

    // spare command code, must leave the envelope alone
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic                   aclk           = 1'b0;
    logic                   aresetn        = 1'b0;
    logic                   s_valid        = 1'b0;
    logic                   s_ready;
    logic [1:0]             s_cmd          = CMD_TICK;
    logic                   s_fade_request = 1'b0;
    logic                   m_valid;
    logic                   m_ready        = 1'b0;
    logic [LEVEL_OUT_W-1:0] m_level;
    logic [1:0]             m_mode;
    logic                   cfg_valid      = 1'b0;
    logic                   cfg_ready;
    logic [1:0]             cfg_addr       = REG_ATTACK;
    logic [RATE_W-1:0]      cfg_data       = '0;

    int fail_count;
    int words_in_flight;
    int words_sent    = 0;
    int cycle_count   = 0;
    int s_idle_pct    = IDLE_PCT;
    int m_idle_pct    = IDLE_PCT;
    bit stall_request = 1'b0;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    adsr_envelope_generator #(
        .LEVEL_FRAC_BITS(FRAC_BITS)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_fade_request (s_fade_request),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_level        (m_level),
        .m_mode         (m_mode),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_addr       (cfg_addr),
        .cfg_data       (cfg_data)
    );

    adsr_checker #(
        .LEVEL_FRAC_BITS(FRAC_BITS)
    ) checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cmd           (s_cmd),
        .s_fade_request  (s_fade_request),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_level         (m_level),
        .m_mode          (m_mode),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_addr        (cfg_addr),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .words_in_flight (words_in_flight)
    );

    // Offer one word, with random idle cycles ahead of it; returns at a falling edge
    task automatic put_word(input logic [1:0] cmd, input logic fade);
        while ($urandom_range(99) < s_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_cmd          <= cmd;
        s_fade_request <= fade;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        words_sent++;
    endtask

    // Sample ticks, fade on about one in fade_odds, optional stray words mixed in
    task automatic run_ticks(input int count, input int fade_odds, input bit with_noise);
        for (int i = 0; i < count; i++) begin
            if (with_noise && $urandom_range(19) == 0)
                put_word(2'($urandom_range(3)), 1'($urandom_range(1)));
            put_word(CMD_TICK, $urandom_range(fade_odds - 1) == 0);
        end
    endtask

    // Stop sending and let every outstanding word come back
    task automatic quiesce();
        s_valid <= 1'b0;
        while (words_in_flight != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    // Write all four registers back to back; block must be idle
    task automatic write_config(input logic [RATE_W-1:0] atk, input logic [RATE_W-1:0] dec,
                                input logic [RATE_W-1:0] sus, input logic [RATE_W-1:0] rel);
        logic [RATE_W-1:0] vals [4];
        logic [1:0]        regs [4];
        vals = '{atk, dec, sus, rel};
        regs = '{REG_ATTACK, REG_DECAY, REG_SUSTAIN, REG_RELEASE};
        for (int i = 0; i < 4; i++) begin
            cfg_valid <= 1'b1;
            cfg_addr  <= regs[i];
            cfg_data  <= vals[i];
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            @(negedge aclk);
        end
        cfg_valid <= 1'b0;
    endtask

    // Result side: random back-pressure, or a long hold-off on request
    initial begin
        forever begin
            @(negedge aclk);
            if (stall_request) begin
                m_ready <= 1'b0;
                repeat (STALL_CYCLES) @(negedge aclk);
                stall_request = 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= m_idle_pct);
            end
        end
    end

    // Run limit
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("adsr_envelope_generator verification failed");
        $finish;
    end

    initial begin
        logic [RATE_W-1:0] atk;
        logic [RATE_W-1:0] dec;
        logic [RATE_W-1:0] sus;
        logic [RATE_W-1:0] rel;
        int                phase;

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // idle after reset with zero registers, fade below zero, spare command,
        // zero attack rate holding the level, key words ignoring the fade bit
        put_word(CMD_TICK, 1'b0);
        put_word(CMD_TICK, 1'b1);
        put_word(CMD_UNUSED, 1'b1);
        put_word(CMD_KEY_ON, 1'b1);
        put_word(CMD_TICK, 1'b0);
        put_word(CMD_TICK, 1'b1);
        put_word(CMD_KEY_OFF, 1'b1);
        put_word(CMD_TICK, 1'b0);

        // release step plus fade leaves a tiny level that the floor clears
        quiesce();
        write_config(7'd64, 7'd0, 7'd0, 7'd127);
        put_word(CMD_KEY_ON, 1'b0);
        put_word(CMD_TICK, 1'b0);
        put_word(CMD_KEY_OFF, 1'b0);
        put_word(CMD_TICK, 1'b1);

        // all registers at the top of their range
        quiesce();
        write_config(7'd127, 7'd127, 7'd127, 7'd127);
        put_word(CMD_KEY_ON, 1'b0);
        put_word(CMD_TICK, 1'b0);
        put_word(CMD_TICK, 1'b1);
        put_word(CMD_TICK, 1'b0);
        put_word(CMD_UNUSED, 1'b0);
        put_word(CMD_KEY_OFF, 1'b0);
        put_word(CMD_TICK, 1'b0);
        put_word(CMD_TICK, 1'b1);

        // random notes: key-on, attack, decay, key-off, release
        words_sent = 0;
        phase      = 0;
        while (words_sent < RANDOM_WORDS) begin
            case (phase % 4)
                0: begin
                    atk = 7'd127;
                    dec = 7'd127;
                    sus = 7'($urandom_range(127));
                    rel = 7'd127;
                end
                1: begin
                    atk = 7'd127;
                    dec = 7'($urandom_range(127));
                    sus = 7'd0;
                    rel = 7'($urandom_range(127));
                end
                2: begin
                    atk = 7'($urandom_range(127));
                    dec = 7'd0;
                    sus = 7'd127;
                    rel = 7'd0;
                end
                default: begin
                    atk = 7'($urandom_range(127));
                    dec = 7'($urandom_range(127));
                    sus = 7'($urandom_range(127));
                    rel = 7'($urandom_range(127));
                end
            endcase
            quiesce();
            write_config(atk, dec, sus, rel);

            // every fourth note runs with no idling on either side
            s_idle_pct = (phase % 4 == 1) ? 0 : IDLE_PCT;
            m_idle_pct = (phase % 4 == 1) ? 0 : IDLE_PCT;

            // one long hold-off on the result side while words keep coming
            if (phase == 0) begin
                @(posedge aclk);
                stall_request = 1'b1;
                @(negedge aclk);
            end

            put_word(CMD_KEY_ON, 1'($urandom_range(1)));
            // fast attack gets a long run of ticks, which may clamp and enter decay
            run_ticks((atk >= 7'd120) ? 256 + $urandom_range(24) : $urandom_range(40, 1),
                      16, 1'b0);
            run_ticks($urandom_range(60, 5), 4, 1'b1);
            put_word(CMD_KEY_OFF, 1'($urandom_range(1)));
            run_ticks($urandom_range(60, 5), 4, 1'b1);
            phase++;
        end

        quiesce();
        if (fail_count == 0 && words_in_flight == 0) begin
            $display("adsr_envelope_generator verification clean");
        end else begin
            $display("adsr_envelope_generator verification failed");
        end
        $finish;
    end

endmodule
